// File: rtl/mdf_pkg.sv
`default_nettype none
package mdf_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_LOAD,
    ST_MUL,
    ST_DIVLD,
    ST_DIV,
    ST_POST,
    ST_MINIT,
    ST_BOUND,
    ST_CLAMP,
    ST_END,
    ST_FIN
  } mdf_state_t;

  // weighted mean being formed by the shared unit
  typedef enum logic [1:0] {
    OP_PM,
    OP_PD,
    OP_PU
  } mdf_op_t;

endpackage
`default_nettype wire

// File: rtl/monotonic_derivative_filter_unit.sv
`default_nettype none
// Hyman monotonicity filter over a stream of spline knots. Each input beat
// brings one knot's unfiltered derivative and the slope and width of the
// segment after it; the filtered derivative of a knot comes out one beat
// later, with a flag when the filter changed it. The beat marked last gives
// two results, the second flagged last_result (a lone knot gives only one),
// and the block then returns to its reset state. All values are signed
// fixed point with like scaling, so the fraction position does not enter
// the arithmetic. One shift-add multiplier and restoring divider, one bit
// per cycle, forms every weighted mean; an end knot does not use it. An
// inner knot needs it for the mean slope and for each of the left and
// right parabola bounds when they apply. The multiplier takes W-1 steps
// per product and the divider 2W+1 steps per quotient, W = DATA_WIDTH.
// The input is stalled while a knot is being worked on; a finished result
// waits in the output register without holding up the next input beat.
module monotonic_derivative_filter_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire signed [DATA_WIDTH-1:0] in_initial_derivative,
  input  wire signed [DATA_WIDTH-1:0] in_segment_slope,
  input  wire        [DATA_WIDTH-2:0] in_segment_width,
  input  wire                         in_is_last_point,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_point_derivative,
  output logic                        out_was_adjusted,
  output logic                        out_last_result
);
  import mdf_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + 1;      // accumulator of two products
  localparam int XW = W + 3;          // means and parabola bounds
  localparam int MW = W + 2;          // magnitude bounds
  localparam int CW = $clog2(NW + 1);

  mdf_state_t state_r, state_nxt;
  mdf_op_t    op_r, op_nxt;
  logic       term_r, term_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [NW-1:0]        mcand_r, mcand_nxt;
  logic [W-2:0]         mb_r, mb_nxt;
  logic                 msign_r, msign_nxt;
  logic signed [NW-1:0] acc_r, acc_nxt;
  logic [NW-1:0]        qr_r, qr_nxt;
  logic                 qneg_r, qneg_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         den_r, den_nxt;
  logic signed [XW-1:0] pm_r, pm_nxt;
  logic signed [XW-1:0] val_r, val_nxt;
  logic [MW-1:0]        m_r, m_nxt;

  // slope and width window of the pending knot: index 0 oldest
  logic signed [W-1:0] s0_r, s1_r, s2_r, s0_nxt, s1_nxt, s2_nxt;
  logic [W-2:0]        w0_r, w1_r, w2_r, w0_nxt, w1_nxt, w2_nxt;
  logic signed [W-1:0] pend_r, pend_nxt;
  logic [1:0]          pos_r, pos_nxt;
  logic                pend_v_r, pend_v_nxt;
  logic                phase2_r, phase2_nxt;

  // latched input beat
  logic signed [W-1:0] din_r, din_nxt, sin_r, sin_nxt;
  logic [W-2:0]        win_r, win_nxt;
  logic                lastin_r, lastin_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic signed [W-1:0] out_d_r, out_d_nxt;
  logic                out_adj_r, out_adj_nxt, out_last_r, out_last_nxt;

  logic in_acc, out_free;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_point_derivative = out_d_r;
  assign out_was_adjusted     = out_adj_r;
  assign out_last_result      = out_last_r;

  function automatic logic [XW-1:0] mag_x(input logic signed [XW-1:0] x);
    mag_x = x[XW-1] ? XW'(-x) : XW'(x);
  endfunction

  // slope differences for the bound preconditions
  logic signed [W:0] d10, d21, dn2, pu_a;
  logic pd_go, pu_go;
  assign d10  = (W+1)'(s1_r) - (W+1)'(s0_r);
  assign d21  = (W+1)'(s2_r) - (W+1)'(s1_r);
  assign dn2  = (W+1)'(sin_r) - (W+1)'(s2_r);
  assign pu_a = (W+1)'(s2_r) - (W+1)'(sin_r);
  assign pd_go = (pos_r == 2'd2) && (d10 != '0) && (d21 != '0) && (d10[W] == d21[W]);
  assign pu_go = !lastin_r && (d21 != '0) && (dn2 != '0) && (d21[W] == dn2[W]);

  // operand select for the shared unit
  logic signed [W:0] a_sel;
  logic [W-2:0]      b_sel;
  logic [W:0]        a_mag;
  logic [W-1:0]      den_sel;
  always_comb begin
    a_sel   = '0;
    b_sel   = '0;
    den_sel = '0;
    case (op_r)
      OP_PM: begin
        a_sel   = term_r ? (W+1)'(s2_r) : (W+1)'(s1_r);
        b_sel   = term_r ? w1_r : w2_r;
        den_sel = W'(w1_r) + W'(w2_r);
      end
      OP_PD: begin
        a_sel   = d10;
        b_sel   = w1_r;
        den_sel = W'(w0_r) + W'(w1_r);
      end
      OP_PU: begin
        a_sel   = pu_a;
        b_sel   = w2_r;
        den_sel = W'(w2_r) + W'(win_r);
      end
      default: begin
        a_sel = '0;
      end
    endcase
    a_mag = a_sel[W] ? (W+1)'(-a_sel) : (W+1)'(a_sel);
  end

  // divider step
  logic [W:0]  rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_r, qr_r[NW-1]};
  assign q_bit  = (rem_sh >= (W+1)'(den_r));

  // signed quotient and bound candidate
  logic [XW-1:0]        q_mag;
  logic signed [XW-1:0] q_val, base_sel;
  assign q_mag    = (den_r == '0) ? '0 : qr_r[XW-1:0];
  assign q_val    = qneg_r ? $signed(XW'(-q_mag)) : $signed(q_mag);
  assign base_sel = (op_r == OP_PD) ? XW'(s1_r) : (op_r == OP_PU) ? XW'(s2_r) : '0;

  logic [XW-1:0] pm_mag, val_mag, s1_mag, s2_mag, min3, min2;
  logic [MW-1:0] c_bound;
  logic          want_neg, bound_ok;
  always_comb begin
    pm_mag  = mag_x(pm_r);
    val_mag = mag_x(val_r);
    s1_mag  = mag_x(XW'(s1_r));
    s2_mag  = mag_x(XW'(s2_r));
    min3    = (s1_mag < s2_mag) ? s1_mag : s2_mag;
    if (pm_mag < min3) begin
      min3 = pm_mag;
    end
    min2    = (pm_mag < val_mag) ? pm_mag : val_mag;
    c_bound = MW'((MW'(min2) + (MW'(min2) << 1)) >> 1);
    // pm must lean with the left slope step for pd, against the right one for pu
    want_neg = (op_r == OP_PD) ? d10[W] : !d21[W];
    bound_ok = (pm_r != '0) && (val_r != '0) && (pm_r[XW-1] == want_neg) &&
               (val_r[XW-1] == want_neg);
  end

  // clamp of a derivative against a reference sign and a magnitude bound
  logic signed [W-1:0] cl_d, cl_r;
  logic [W-1:0]        cl_dabs;
  logic                cl_ref_neg, cl_ref_nz, cl_adj;
  logic [MW-1:0]       cl_bound, s2_3, cl_dmag, cl_rmag;
  always_comb begin
    s2_3 = MW'(s2_mag) + (MW'(s2_mag) << 1);
    if (state_r == ST_CLAMP) begin
      cl_d       = pend_r;
      cl_ref_neg = pm_r[XW-1];
      cl_ref_nz  = (pm_r != '0);
      cl_bound   = m_r;
    end else begin
      cl_d       = phase2_r ? din_r : pend_r;
      cl_ref_neg = s2_r[W-1];
      cl_ref_nz  = (s2_r != '0);
      cl_bound   = s2_3;
    end
    // unsigned magnitude, so the most negative value widens correctly
    cl_dabs = cl_d[W-1] ? W'(-cl_d) : W'(cl_d);
    cl_dmag = MW'(cl_dabs);
    cl_rmag = (cl_dmag < cl_bound) ? cl_dmag : cl_bound;
    if ((cl_d != '0) && cl_ref_nz && (cl_d[W-1] == cl_ref_neg)) begin
      cl_r = cl_d[W-1] ? W'(-cl_rmag) : W'(cl_rmag);
    end else begin
      cl_r = '0;
    end
    cl_adj = (cl_r != cl_d);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!pend_v_r) begin
            state_nxt = in_is_last_point ? ST_PASS : ST_IDLE;
          end else begin
            state_nxt = (pos_r == 2'd0) ? ST_END : ST_LOAD;
          end
        end
      end
      ST_PASS:  state_nxt = out_free ? ST_IDLE : ST_PASS;
      ST_LOAD:  state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == CW'(W - 2)) begin
          state_nxt = (op_r == OP_PM && !term_r) ? ST_LOAD : ST_DIVLD;
        end
      end
      ST_DIVLD: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (cnt_r == CW'(NW - 1)) ? ST_POST : ST_DIV;
      ST_POST:  state_nxt = (op_r == OP_PM) ? ST_MINIT : ST_BOUND;
      ST_MINIT: state_nxt = (pd_go || pu_go) ? ST_LOAD : ST_CLAMP;
      ST_BOUND: state_nxt = (op_r == OP_PD && pu_go) ? ST_LOAD : ST_CLAMP;
      ST_CLAMP: state_nxt = out_free ? ST_FIN : ST_CLAMP;
      ST_END: begin
        if (out_free) begin
          state_nxt = phase2_r ? ST_IDLE : ST_FIN;
        end
      end
      ST_FIN:   state_nxt = lastin_r ? ST_END : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and window updates
  always_comb begin
    op_nxt = op_r;       term_nxt = term_r;   cnt_nxt = cnt_r;
    mcand_nxt = mcand_r; mb_nxt = mb_r;       msign_nxt = msign_r;
    acc_nxt = acc_r;     qr_nxt = qr_r;       qneg_nxt = qneg_r;
    rem_nxt = rem_r;     den_nxt = den_r;     pm_nxt = pm_r;
    val_nxt = val_r;     m_nxt = m_r;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r;
    w0_nxt = w0_r; w1_nxt = w1_r; w2_nxt = w2_r;
    pend_nxt = pend_r;   pos_nxt = pos_r;     pend_v_nxt = pend_v_r;
    phase2_nxt = phase2_r;
    din_nxt = din_r; sin_nxt = sin_r; win_nxt = win_r; lastin_nxt = lastin_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_d_nxt = out_d_r; out_adj_nxt = out_adj_r; out_last_nxt = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          din_nxt    = in_initial_derivative;
          sin_nxt    = in_segment_slope;
          win_nxt    = in_segment_width;
          lastin_nxt = in_is_last_point;
          phase2_nxt = 1'b0;
          op_nxt     = OP_PM;
          term_nxt   = 1'b0;
          if (!pend_v_r && !in_is_last_point) begin
            // first knot: hold it as pending
            s2_nxt     = in_segment_slope;
            w2_nxt     = in_segment_width;
            pend_nxt   = in_initial_derivative;
            pos_nxt    = 2'd0;
            pend_v_nxt = 1'b1;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_d_nxt     = din_r;
          out_adj_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          pos_nxt       = 2'd0;
        end
      end
      ST_LOAD: begin
        mcand_nxt = NW'(a_mag);
        msign_nxt = a_sel[W];
        mb_nxt    = b_sel;
        cnt_nxt   = '0;
        if (!term_r) begin
          acc_nxt = '0;
          den_nxt = den_sel;
        end
      end
      ST_MUL: begin
        if (mb_r[0]) begin
          acc_nxt = msign_r ? acc_r - $signed(mcand_r) : acc_r + $signed(mcand_r);
        end
        mcand_nxt = mcand_r << 1;
        mb_nxt    = mb_r >> 1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CW'(W - 2) && op_r == OP_PM && !term_r) begin
          term_nxt = 1'b1;
        end
      end
      ST_DIVLD: begin
        qr_nxt   = acc_r[NW-1] ? NW'(-acc_r) : NW'(acc_r);
        qneg_nxt = acc_r[NW-1];
        rem_nxt  = '0;
        cnt_nxt  = '0;
      end
      ST_DIV: begin
        rem_nxt = q_bit ? W'(rem_sh - (W+1)'(den_r)) : W'(rem_sh);
        qr_nxt  = {qr_r[NW-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_POST: begin
        if (op_r == OP_PM) begin
          pm_nxt = q_val;
        end else begin
          val_nxt = base_sel + q_val;
        end
      end
      ST_MINIT: begin
        m_nxt    = MW'(min3) + (MW'(min3) << 1);
        op_nxt   = pd_go ? OP_PD : OP_PU;
        term_nxt = 1'b0;
      end
      ST_BOUND: begin
        if (bound_ok && (c_bound > m_r)) begin
          m_nxt = c_bound;
        end
        op_nxt   = OP_PU;
        term_nxt = 1'b0;
      end
      ST_CLAMP, ST_END: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_d_nxt     = cl_r;
          out_adj_nxt   = cl_adj;
          out_last_nxt  = phase2_r;
          if (phase2_r) begin
            pend_v_nxt = 1'b0;
            pos_nxt    = 2'd0;
            phase2_nxt = 1'b0;
          end
        end
      end
      ST_FIN: begin
        if (lastin_r) begin
          phase2_nxt = 1'b1;
        end else begin
          // advance the window to the new knot
          s0_nxt   = s1_r; s1_nxt = s2_r; s2_nxt = sin_r;
          w0_nxt   = w1_r; w1_nxt = w2_r; w2_nxt = win_r;
          pend_nxt = din_r;
          if (pos_r != 2'd2) begin
            pos_nxt = pos_r + 2'd1;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      pos_r       <= 2'd0;
      phase2_r    <= 1'b0;
      op_r        <= OP_PM;
      term_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      pos_r       <= pos_nxt;
      phase2_r    <= phase2_nxt;
      op_r        <= op_nxt;
      term_r      <= term_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt; mb_r <= mb_nxt;   msign_r <= msign_nxt;
    acc_r   <= acc_nxt;   qr_r <= qr_nxt;   qneg_r  <= qneg_nxt;
    rem_r   <= rem_nxt;   den_r <= den_nxt; pm_r    <= pm_nxt;
    val_r   <= val_nxt;   m_r  <= m_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt;
    w0_r <= w0_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt;
    pend_r <= pend_nxt;
    din_r <= din_nxt; sin_r <= sin_nxt; win_r <= win_nxt; lastin_r <= lastin_nxt;
    out_d_r <= out_d_nxt; out_adj_r <= out_adj_nxt; out_last_r <= out_last_nxt;
  end

  // only the mean slope takes a second product
  a_second_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && term_r) |-> (op_r == OP_PM))
    else $error("second product outside the mean slope");

  // the shared unit runs only for an inner knot
  a_inner_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (pend_v_r && pos_r != 2'd0))
    else $error("arithmetic started without an inner knot pending");

  // a new result appears only from an emitting state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_CLAMP || $past(state_r) == ST_END ||
                            $past(state_r) == ST_PASS))
    else $error("result raised outside an emitting state");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int W = 32;
  typedef logic signed [95:0] wide_t;

  // one knot as offered on the input channel
  typedef struct {
    logic signed [W-1:0] deriv;
    logic signed [W-1:0] slope;
    logic [W-2:0]        width;
    logic                last;
  } knot_t;

  // one filtered derivative as the block should report it
  typedef struct {
    logic [W-1:0] deriv;
    logic         adj;
    logic         last;
  } filtered_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] in_initial_derivative = '0;
  logic signed [W-1:0] in_segment_slope = '0;
  logic [W-2:0] in_segment_width = '0;
  logic in_is_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_point_derivative;
  logic out_was_adjusted;
  logic out_last_result;

  monotonic_derivative_filter_unit #(.DATA_WIDTH(W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_initial_derivative(in_initial_derivative),
    .in_segment_slope(in_segment_slope),
    .in_segment_width(in_segment_width),
    .in_is_last_point(in_is_last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_derivative(out_point_derivative),
    .out_was_adjusted(out_was_adjusted),
    .out_last_result(out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  knot_t knot_queue[$];
  filtered_t filtered_queue[$];
  int mismatches = 0;
  int cycle = 0;
  int beats_in = 0;
  int beats_offered = 0;
  int hold_off = 0;
  bit hold_done = 1'b0;

  // predictor state: window of three slopes and widths, pending knot
  wide_t slope_win[3];
  wide_t width_win[3];
  wide_t pend_deriv;
  int    knot_pos;
  bit    pend_valid;

  function automatic int sgn(wide_t x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic wide_t mag(wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wide_t wmin(wide_t a, wide_t b);
    return (a < b) ? a : b;
  endfunction

  // a zero width sum makes the weighted term drop out
  function automatic wide_t weighted(wide_t num, wide_t den);
    return (den > 0) ? num / den : 0;
  endfunction

  function automatic filtered_t clamp_deriv(wide_t d, wide_t ref_s, wide_t bound);
    filtered_t f;
    wide_t r;
    r = 0;
    if (sgn(d) != 0 && sgn(d) == sgn(ref_s)) begin
      r = wmin(mag(d), bound);
      if (d < 0) r = -r;
    end
    f.deriv = r[W-1:0];
    f.adj = (r != d);
    f.last = 1'b0;
    return f;
  endfunction

  function automatic filtered_t inner_deriv(bit has_pd, bit has_pu, wide_t s_nx, wide_t w_nx);
    wide_t s0, s1, s2, w0, w1, w2, pm, bound, pd, pu, c;
    s0 = slope_win[0]; s1 = slope_win[1]; s2 = slope_win[2];
    w0 = width_win[0]; w1 = width_win[1]; w2 = width_win[2];
    pm = weighted(s1 * w2 + s2 * w1, w1 + w2);
    bound = 3 * wmin(wmin(mag(s1), mag(s2)), mag(pm));
    // widen by the left parabola bound where the slopes run one way
    if (has_pd && sgn(s1 - s0) != 0 && sgn(s1 - s0) == sgn(s2 - s1)) begin
      pd = s1 + weighted((s1 - s0) * w1, w0 + w1);
      if (sgn(pm) != 0 && sgn(pm) == sgn(pd) && sgn(pm) == sgn(s1 - s0)) begin
        c = (3 * wmin(mag(pm), mag(pd))) >>> 1;
        if (c > bound) bound = c;
      end
    end
    // and by the right one
    if (has_pu && sgn(s2 - s1) != 0 && sgn(s2 - s1) == sgn(s_nx - s2)) begin
      pu = s2 + weighted((s2 - s_nx) * w2, w2 + w_nx);
      if (sgn(pm) != 0 && sgn(pm) == sgn(pu) && sgn(pm) == -sgn(s2 - s1)) begin
        c = (3 * wmin(mag(pm), mag(pu))) >>> 1;
        if (c > bound) bound = c;
      end
    end
    return clamp_deriv(pend_deriv, pm, bound);
  endfunction

  function automatic filtered_t release_knot(bit has_pu, wide_t s_nx, wide_t w_nx);
    if (knot_pos == 0) return clamp_deriv(pend_deriv, slope_win[2], 3 * mag(slope_win[2]));
    return inner_deriv(knot_pos >= 2, has_pu, s_nx, w_nx);
  endfunction

  function automatic void clear_window();
    for (int k = 0; k < 3; k++) begin
      slope_win[k] = 0;
      width_win[k] = 0;
    end
    pend_deriv = 0;
    knot_pos = 0;
    pend_valid = 1'b0;
  endfunction

  // work out the results that one accepted knot causes
  function automatic void filter_knot(knot_t k);
    filtered_t f;
    wide_t d, s, w;
    d = k.deriv;
    s = k.slope;
    w = {65'd0, k.width};
    if (!pend_valid) begin
      if (k.last) begin
        // single knot curve: passed through untouched
        f.deriv = k.deriv; f.adj = 1'b0; f.last = 1'b1;
        filtered_queue.push_back(f);
        clear_window();
      end else begin
        slope_win[2] = s; width_win[2] = w; pend_deriv = d;
        knot_pos = 0; pend_valid = 1'b1;
      end
    end else if (k.last) begin
      filtered_queue.push_back(release_knot(1'b0, 0, 0));
      f = clamp_deriv(d, slope_win[2], 3 * mag(slope_win[2]));
      f.last = 1'b1;
      filtered_queue.push_back(f);
      clear_window();
    end else begin
      filtered_queue.push_back(release_knot(1'b1, s, w));
      slope_win[0] = slope_win[1]; slope_win[1] = slope_win[2]; slope_win[2] = s;
      width_win[0] = width_win[1]; width_win[1] = width_win[2]; width_win[2] = w;
      pend_deriv = d;
      if (knot_pos < 2) knot_pos++;
    end
  endfunction

  function automatic void add_knot(logic [W-1:0] d, logic [W-1:0] s, logic [W-2:0] w,
                                   logic last);
    knot_t k;
    k.deriv = d; k.slope = s; k.width = w; k.last = last;
    knot_queue.push_back(k);
  endfunction

  // one curve: mostly monotone with small widths, sometimes full noise
  function automatic void add_curve(int n);
    int mode, sign;
    logic signed [W-1:0] s, d;
    logic [W-2:0] w;
    mode = $urandom_range(0, 9);
    sign = $urandom_range(0, 1) ? 1 : -1;
    s = $urandom_range(0, 1 << 20);
    for (int i = 0; i < n; i++) begin
      if (mode < 7) begin
        s = s + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        d = sign * s * $signed($urandom_range(0, 4)) + $signed($urandom_range(0, 4096)) - 2048;
        w = ($urandom_range(0, 15) == 0) ? '0 : (W-1)'($urandom_range(1, 1 << 20));
        add_knot(d, sign * s, w, i == n - 1);
      end else begin
        w = (mode == 9) ? (W-1)'($urandom) : (W-1)'($urandom_range(0, 1 << 17));
        add_knot($urandom, $urandom, w, i == n - 1);
      end
    end
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && in_valid && !in_stall) begin
      filter_knot('{in_initial_derivative, in_segment_slope, in_segment_width,
                    in_is_last_point});
      beats_in <= beats_in + 1;
    end
  end

  // driver: advance to the next knot once the current beat has gone
  always @(negedge clk) begin
    if (rst_n && (!in_valid || beats_in == beats_offered)) begin
      if (knot_queue.size() > 0 &&
          !((cycle < 20000 || cycle > 60000) && $urandom_range(0, 99) < 16)) begin
        in_valid <= 1'b1;
        in_initial_derivative <= knot_queue[0].deriv;
        in_segment_slope <= knot_queue[0].slope;
        in_segment_width <= knot_queue[0].width;
        in_is_last_point <= knot_queue[0].last;
        void'(knot_queue.pop_front());
        beats_offered <= beats_offered + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off on the result side so the input backs up
  always @(negedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
    else if (!hold_done && beats_in > 100) begin
      hold_off <= 2000;
      hold_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) out_stall <= 1'b1;
    else out_stall <= (cycle >= 20000 && cycle <= 60000) ? 1'b0 : ($urandom_range(0, 99) < 16);
  end

  // monitor: compare every result beat with the oldest prediction
  always @(posedge clk) begin
    filtered_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h", out_point_derivative);
      end else begin
        e = filtered_queue.pop_front();
        if (out_point_derivative !== e.deriv || out_was_adjusted !== e.adj ||
            out_last_result !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h adj %b last %b, got %h adj %b last %b",
                     e.deriv, e.adj, e.last, out_point_derivative, out_was_adjusted,
                     out_last_result);
        end
      end
    end
  end

  initial begin
    clear_window();
    // single knot, two knot and longer curves, extremes and zero widths
    add_knot(32'h7fffffff, 32'h80000000, '0, 1'b1);
    add_knot(32'h80000000, 32'h7fffffff, '1, 1'b0);
    add_knot(32'h80000000, 32'h7fffffff, '1, 1'b1);
    add_knot(32'h00030000, 32'h00010000, 31'h00010000, 1'b0);
    add_knot(32'h00000000, 32'h00000000, 31'h00000000, 1'b1);
    add_knot(32'h00050000, 32'h00010000, 31'h0, 1'b0);
    add_knot(32'h00050000, 32'h00020000, 31'h0, 1'b0);
    add_knot(32'h00090000, 32'h00030000, 31'h0, 1'b0);
    add_knot(32'h000f0000, 32'h00040000, 31'h0, 1'b1);
    add_knot(32'h7fffffff, 32'h7fffffff, '1, 1'b0);
    add_knot(32'h7fffffff, 32'h80000000, '1, 1'b0);
    add_knot(32'h80000000, 32'h7fffffff, '1, 1'b0);
    add_knot(32'h80000000, 32'h80000000, '1, 1'b0);
    add_knot(32'hffff0000, 32'h00000001, 31'h1, 1'b1);
    add_knot(32'h00020000, 32'h00010000, 31'h10000, 1'b0);
    add_knot(32'h00040000, 32'h00020000, 31'h10000, 1'b0);
    add_knot(32'h00080000, 32'h00040000, 31'h10000, 1'b0);
    add_knot(32'h00100000, 32'h00080000, 31'h10000, 1'b0);
    add_knot(32'h00200000, 32'h00100000, 31'h10000, 1'b1);
    while (knot_queue.size() < 520) add_curve($urandom_range(0, 9) == 0 ? 1 :
                                               $urandom_range(2, 8));
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    // the input drops only once the queue is empty and the last beat has gone
    wait (knot_queue.size() == 0 && !in_valid && beats_in == beats_offered);
    wait (filtered_queue.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && filtered_queue.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/mdf_pkg.sv
rtl/monotonic_derivative_filter_unit.sv
tb/testbench.sv
